FILE: hw/rtl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types, codes and constants of the handheld bus decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package hbd_pkg;

    localparam int SPRITE_BYTES_DEF = 160;
    localparam int BANK_BITS_DEF    = 9;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [2:0] {
        MODE_CPU_READ  = 3'd0,
        MODE_CPU_WRITE = 3'd1,
        MODE_PPU_READ  = 3'd2,
        MODE_DMA_STEP  = 3'd3,
        MODE_MAP_PAGE  = 3'd4,
        MODE_IRQ       = 3'd5,
        MODE_NOP6      = 3'd6,
        MODE_NOP7      = 3'd7
    } t_mode;

    // Region of the bus that an access falls in.
    typedef enum logic [3:0] {
        REG_ROM, REG_VRAM, REG_UNMAPPED, REG_WRAM, REG_OAM,
        REG_IO, REG_HRAM, REG_IE
    } t_region;

    localparam logic [1:0] CART_NONE  = 2'd0;
    localparam logic [1:0] CART_READ  = 2'd1;
    localparam logic [1:0] CART_WRITE = 2'd2;

    localparam logic [6:0] IO_DIV  = 7'h04;
    localparam logic [6:0] IO_IF   = 7'h0F;
    localparam logic [6:0] IO_STAT = 7'h41;
    localparam logic [6:0] IO_LY   = 7'h44;
    localparam logic [6:0] IO_DMA  = 7'h46;
    localparam logic [6:0] IO_BGP  = 7'h47;
    localparam logic [6:0] IO_OBP1 = 7'h49;

    // Classified item handed from front to back.
    typedef struct packed {
        t_mode        mode;
        t_region      region;
        logic [15:0]  address;
        logic [7:0]   write_data;
        logic [1:0]   video_mode;
        logic [7:0]   cart_data;
        logic [2:0]   page_index;
        logic [8:0]   bank_number;
        logic [2:0]   irq_kind;
        logic         high_space;
    } t_item;

    function automatic t_region region_of(input logic [15:0] a);
        t_region r;
        if (a < 16'h8000)      r = REG_ROM;
        else if (a < 16'hA000) r = REG_VRAM;
        else if (a < 16'hC000) r = REG_UNMAPPED;
        else if (a < 16'hFE00) r = REG_WRAM;
        else if (a < 16'hFEA0) r = REG_OAM;
        else if (a < 16'hFF00) r = REG_UNMAPPED;
        else if (a < 16'hFF80) r = REG_IO;
        else if (a < 16'hFFFF) r = REG_HRAM;
        else                   r = REG_IE;
        return r;
    endfunction

    // Power-on value of an IO register.
    function automatic logic [7:0] io_init(input logic [6:0] r);
        logic [7:0] v;
        case (r)
            7'h10: v = 8'h80;
            7'h11: v = 8'hBF;
            7'h12: v = 8'hF3;
            7'h14: v = 8'hBF;
            7'h16: v = 8'h3F;
            7'h19: v = 8'hBF;
            7'h1A: v = 8'h7F;
            7'h1B: v = 8'hFF;
            7'h1C: v = 8'h9F;
            7'h1E: v = 8'hBF;
            7'h20: v = 8'hFF;
            7'h23: v = 8'hBF;
            7'h24: v = 8'h77;
            7'h25: v = 8'hF3;
            7'h26: v = 8'hF1;
            7'h40: v = 8'h91;
            7'h47: v = 8'hFC;
            7'h48: v = 8'hFF;
            7'h49: v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hbd_front.sv
// ----------------------------------------------------------------------------
// hbd_front
// Accepts bus items, classifies the address and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module hbd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [2:0]    i_mode,
    input  wire logic [15:0]   i_address,
    input  wire logic [7:0]    i_write_data,
    input  wire logic [1:0]    i_video_mode,
    input  wire logic [7:0]    i_cart_data,
    input  wire logic [2:0]    i_page_index,
    input  wire logic [8:0]    i_bank_number,
    input  wire logic [2:0]    i_irq_kind,
    output logic               o_item_valid,
    output hbd_pkg::t_item     o_item,
    input  wire logic          i_item_take
);
    hbd_pkg::t_item r_q [hbd_pkg::QUEUE_DEPTH];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt, n_cnt;
    hbd_pkg::t_item w_item;
    logic           w_push, w_pop;

    // Classification of the incoming transaction.
    always_comb begin
        w_item.mode        = hbd_pkg::t_mode'(i_mode);
        w_item.region      = hbd_pkg::region_of(i_address);
        w_item.address     = i_address;
        w_item.write_data  = i_write_data;
        w_item.video_mode  = i_video_mode;
        w_item.cart_data   = i_cart_data;
        w_item.page_index  = i_page_index;
        w_item.bank_number = i_bank_number;
        w_item.irq_kind    = i_irq_kind;
        w_item.high_space  = (i_address >= 16'hFF80);
    end

    assign o_ready      = (r_cnt != 2'(hbd_pkg::QUEUE_DEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign w_pop        = o_item_valid && i_item_take;
    assign o_item       = r_q[r_rp];
    assign n_cnt        = r_cnt + 2'(w_push) - 2'(w_pop);

    // Two-entry queue between front and back.
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/hbd_back.sv
// ----------------------------------------------------------------------------
// hbd_back
// Carries out one classified access per cycle, unless stalled, on the internal stores.
// ----------------------------------------------------------------------------
`default_nettype none
module hbd_back #(
    parameter int SPRITE_BYTES = hbd_pkg::SPRITE_BYTES_DEF,
    parameter int BANK_BITS    = hbd_pkg::BANK_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_item_valid,
    input  hbd_pkg::t_item     i_item,
    output logic               o_item_take,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_read_data,
    output logic [1:0]         o_cart_access,
    output logic [22:0]        o_cart_address,
    output logic               o_divider_reset,
    output logic               o_palette_update,
    output logic               o_dma_busy,
    output logic [15:0]        o_dma_next_source,
    output logic [7:0]         o_irq_flags
);
    localparam int OAM_AW = (SPRITE_BYTES > 1) ? $clog2(SPRITE_BYTES) : 1;

    // Store that feeds the registered read data.
    localparam logic [2:0] RAM_VRAM = 3'd0;
    localparam logic [2:0] RAM_WRAM = 3'd1;
    localparam logic [2:0] RAM_OAM  = 3'd2;
    localparam logic [2:0] RAM_HRAM = 3'd3;
    localparam logic [2:0] RAM_IO   = 3'd4;

    logic [7:0] r_vram [8192];
    logic [7:0] r_wram [8192];
    logic [7:0] r_oam  [SPRITE_BYTES];
    logic [7:0] r_hram [127];
    logic [7:0] r_io   [128];
    logic [127:0] r_io_wr;
    logic [BANK_BITS-1:0] r_bank [4];
    logic [7:0]  r_ie, r_if, n_if;
    logic        r_dma_on, n_dma_on;
    logic [15:0] r_dma_base, n_dma_base;
    logic [7:0]  r_dma_count, n_dma_count;

    // Output stage registers.
    logic        r_valid;
    logic        r_sel_ram;
    logic [7:0]  r_ram_data, r_rd, n_rd;
    logic [1:0]  r_cacc, n_cacc;
    logic [22:0] r_caddr, n_caddr;
    logic        r_divr, n_divr, r_pal, n_pal, n_sel;
    logic [2:0]  n_ram;
    logic [12:0] n_ram_addr;

    // OAM write of a DMA step, done in the cycle after its source read.
    logic              r_pw, n_pw;
    logic [OAM_AW-1:0] r_pw_addr;

    hbd_pkg::t_item it;
    logic [15:0] w_src, w_acc;
    hbd_pkg::t_region w_reg;
    logic        w_blocked, w_lock, w_go, w_vwr, w_wwr, w_owr, w_hwr, w_iowr;
    logic [7:0]  w_oam_k, w_io_wdata;
    logic [OAM_AW-1:0] w_oam_waddr;
    logic [6:0]  w_ior;

    assign it          = i_item;
    assign o_item_take = i_item_valid && !r_pw && (!r_valid || i_ready);
    assign w_go        = o_item_take;
    assign w_src       = r_dma_base + {8'd0, r_dma_count};
    assign w_acc       = (it.mode == hbd_pkg::MODE_DMA_STEP) ? w_src : it.address;
    assign w_reg       = (it.mode == hbd_pkg::MODE_DMA_STEP) ?
                         hbd_pkg::region_of(w_src) : it.region;
    assign w_blocked   = r_dma_on && !it.high_space;
    assign w_lock      = it.video_mode[1];
    assign w_oam_k     = 8'(w_acc - 16'hFE00);
    assign w_ior       = it.address[6:0];

    function automatic logic [22:0] rom_addr(input logic [15:0] a,
                                             input logic [BANK_BITS-1:0] b);
        logic [22:0] r;
        if (a < 16'h4000) r = {7'd0, a};
        else r = 23'({b, 14'd0}) + {9'd0, a[13:0]};
        return r;
    endfunction

    // Decode of the item into store writes, state updates and output fields.
    always_comb begin
        n_rd = 8'h00; n_cacc = hbd_pkg::CART_NONE; n_caddr = 23'd0;
        n_divr = 1'b0; n_pal = 1'b0; n_sel = 1'b0; n_ram = RAM_VRAM;
        n_ram_addr = w_acc[12:0];
        n_if = r_if; n_dma_on = r_dma_on; n_dma_base = r_dma_base;
        n_dma_count = r_dma_count;
        w_vwr = 1'b0; w_wwr = 1'b0; w_owr = 1'b0; w_hwr = 1'b0; w_iowr = 1'b0;
        n_pw = 1'b0;
        w_oam_waddr = OAM_AW'(w_oam_k);
        w_io_wdata = it.write_data;
        case (it.mode)
            hbd_pkg::MODE_CPU_READ: begin
                if (w_blocked) n_rd = 8'hFF;
                else begin
                    case (w_reg)
                        hbd_pkg::REG_ROM: begin
                            n_cacc = hbd_pkg::CART_READ;
                            n_caddr = rom_addr(w_acc, r_bank[w_acc[13:12]]);
                            n_rd = it.cart_data;
                        end
                        hbd_pkg::REG_VRAM: begin
                            if (it.video_mode == 2'd3) n_rd = 8'hFF;
                            else begin n_sel = 1'b1; n_ram = RAM_VRAM; end
                        end
                        hbd_pkg::REG_WRAM: begin n_sel = 1'b1; n_ram = RAM_WRAM; end
                        hbd_pkg::REG_OAM: begin
                            if (w_lock || 32'(w_oam_k) >= SPRITE_BYTES) n_rd = 8'hFF;
                            else begin n_sel = 1'b1; n_ram = RAM_OAM; end
                        end
                        hbd_pkg::REG_IO: begin
                            if (w_ior == hbd_pkg::IO_IF) n_rd = r_if;
                            else begin n_sel = 1'b1; n_ram = RAM_IO; end
                        end
                        hbd_pkg::REG_HRAM: begin n_sel = 1'b1; n_ram = RAM_HRAM; end
                        hbd_pkg::REG_IE: n_rd = r_ie;
                        default: n_rd = 8'hFF;
                    endcase
                end
            end
            hbd_pkg::MODE_CPU_WRITE: begin
                if (!w_blocked) begin
                    case (w_reg)
                        hbd_pkg::REG_ROM: begin
                            n_cacc = hbd_pkg::CART_WRITE;
                            n_caddr = {7'd0, w_acc};
                        end
                        hbd_pkg::REG_VRAM: w_vwr = (it.video_mode != 2'd3);
                        hbd_pkg::REG_WRAM: w_wwr = 1'b1;
                        hbd_pkg::REG_OAM:
                            w_owr = !w_lock && 32'(w_oam_k) < SPRITE_BYTES;
                        hbd_pkg::REG_IO: begin
                            if (w_ior == hbd_pkg::IO_DIV) n_divr = 1'b1;
                            else if (w_ior == hbd_pkg::IO_STAT) begin
                                // STAT bits 2..0 are never set by the bus and stay zero.
                                w_iowr = 1'b1;
                                w_io_wdata = it.write_data & 8'hF8;
                            end else if (w_ior == hbd_pkg::IO_LY) begin
                                w_iowr = 1'b1; w_io_wdata = 8'h00;
                            end else begin
                                w_iowr = 1'b1;
                                if (w_ior == hbd_pkg::IO_IF) n_if = it.write_data;
                                else if (w_ior == hbd_pkg::IO_DMA) begin
                                    n_dma_on = 1'b1;
                                    n_dma_base = {it.write_data, 8'd0};
                                    n_dma_count = 8'd0;
                                end else if (w_ior >= hbd_pkg::IO_BGP &&
                                             w_ior <= hbd_pkg::IO_OBP1) n_pal = 1'b1;
                            end
                        end
                        hbd_pkg::REG_HRAM: w_hwr = 1'b1;
                        hbd_pkg::REG_IE: ;
                        default: ;
                    endcase
                end
            end
            hbd_pkg::MODE_PPU_READ: begin
                if (w_reg == hbd_pkg::REG_VRAM) begin n_sel = 1'b1; n_ram = RAM_VRAM; end
                else if (w_reg == hbd_pkg::REG_OAM && 32'(w_oam_k) < SPRITE_BYTES) begin
                    n_sel = 1'b1; n_ram = RAM_OAM;
                end else n_rd = 8'hFF;
            end
            hbd_pkg::MODE_DMA_STEP: begin
                if (r_dma_on) begin
                    n_pw = 32'(r_dma_count) < SPRITE_BYTES;
                    n_rd = 8'hFF;
                    if (w_reg == hbd_pkg::REG_ROM) begin
                        n_cacc = hbd_pkg::CART_READ;
                        n_caddr = rom_addr(w_acc, r_bank[w_acc[13:12]]);
                        n_rd = it.cart_data;
                    end else if (w_reg == hbd_pkg::REG_VRAM) begin
                        n_sel = 1'b1; n_ram = RAM_VRAM;
                    end else if (w_reg == hbd_pkg::REG_WRAM) begin
                        n_sel = 1'b1; n_ram = RAM_WRAM;
                    end
                    n_dma_count = r_dma_count + 8'd1;
                    if (32'(n_dma_count) >= SPRITE_BYTES) n_dma_on = 1'b0;
                end
            end
            hbd_pkg::MODE_IRQ: n_if = r_if | (8'd1 << it.irq_kind);
            default: ;
        endcase
        w_vwr = w_vwr && w_go; w_wwr = w_wwr && w_go; w_owr = w_owr && w_go;
        w_hwr = w_hwr && w_go; w_iowr = w_iowr && w_go; n_pw = n_pw && w_go;
    end

    // Memories: one registered read port and one write port each.
    always_ff @(posedge i_clk) begin
        if (w_vwr) r_vram[w_acc[12:0]] <= it.write_data;
        if (w_wwr) r_wram[w_acc[12:0]] <= it.write_data;
        // The byte of a DMA step sits in the output stage while it is written.
        if (r_pw) r_oam[r_pw_addr] <= r_sel_ram ? r_ram_data : r_rd;
        else if (w_owr) r_oam[w_oam_waddr] <= it.write_data;
        if (w_hwr) r_hram[w_acc[6:0]] <= it.write_data;
        if (w_iowr) r_io[w_ior] <= w_io_wdata;
        if (w_go) begin
            case (n_ram)
                RAM_VRAM: r_ram_data <= r_vram[n_ram_addr];
                RAM_WRAM: r_ram_data <= r_wram[n_ram_addr];
                RAM_OAM:  r_ram_data <= r_oam[OAM_AW'(w_oam_k)];
                RAM_HRAM: r_ram_data <= r_hram[n_ram_addr[6:0]];
                default:  r_ram_data <= r_io_wr[w_ior] ? r_io[w_ior] :
                                        hbd_pkg::io_init(w_ior);
            endcase
            r_sel_ram <= n_sel; r_rd <= n_rd; r_cacc <= n_cacc;
            r_caddr <= n_caddr; r_divr <= n_divr; r_pal <= n_pal;
            r_pw_addr <= OAM_AW'(r_dma_count);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_ie <= 8'd0; r_if <= 8'd0; r_dma_on <= 1'b0;
            r_dma_base <= 16'd0; r_dma_count <= 8'd0; r_io_wr <= '0;
            r_pw <= 1'b0;
            for (int i = 0; i < 4; i++) r_bank[i] <= BANK_BITS'(1);
        end else begin
            if (w_go) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            r_pw <= n_pw;
            if (w_iowr) r_io_wr[w_ior] <= 1'b1;
            if (w_go) begin
                r_if <= n_if; r_dma_on <= n_dma_on;
                r_dma_base <= n_dma_base; r_dma_count <= n_dma_count;
                if (it.mode == hbd_pkg::MODE_CPU_WRITE && !w_blocked &&
                    w_reg == hbd_pkg::REG_IE) r_ie <= it.write_data;
                if (it.mode == hbd_pkg::MODE_MAP_PAGE && it.page_index[2])
                    r_bank[it.page_index[1:0]] <= it.bank_number[BANK_BITS-1:0];
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_read_data       = r_sel_ram ? r_ram_data : r_rd;
    assign o_cart_access     = r_cacc;
    assign o_cart_address    = r_caddr;
    assign o_divider_reset   = r_divr;
    assign o_palette_update  = r_pal;
    assign o_dma_busy        = r_dma_on;
    assign o_dma_next_source = r_dma_base + {8'd0, r_dma_count};
    assign o_irq_flags       = r_if;
endmodule
`default_nettype wire

FILE: hw/rtl/handheld_bus_decoder_with_oam_dma.sv
// A result is registered in the output stage once the back end takes its item.
// Throughput: one transaction per cycle unless the output stalls; a DMA step
// holds off the next one until its OAM write, which follows the registered
// read of the source byte. The two-entry queue lets the front accept while
// the output waits. Reset is synchronous and clears control state only; RAM
// contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// handheld_bus_decoder_with_oam_dma
// Memory map decoder with internal RAMs, IO registers and OAM DMA engine.
// ----------------------------------------------------------------------------
`default_nettype none
module handheld_bus_decoder_with_oam_dma #(
    parameter int SPRITE_BYTES = hbd_pkg::SPRITE_BYTES_DEF,
    parameter int BANK_BITS    = hbd_pkg::BANK_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [1:0]  i_video_mode,
    input  wire logic [7:0]  i_cart_data,
    input  wire logic [2:0]  i_page_index,
    input  wire logic [8:0]  i_bank_number,
    input  wire logic [2:0]  i_irq_kind,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_read_data,
    output logic [1:0]       o_cart_access,
    output logic [22:0]      o_cart_address,
    output logic             o_divider_reset,
    output logic             o_palette_update,
    output logic             o_dma_busy,
    output logic [15:0]      o_dma_next_source,
    output logic [7:0]       o_irq_flags
);
    logic           w_item_valid, w_item_take;
    hbd_pkg::t_item w_item;

    hbd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_address,
        .i_write_data, .i_video_mode, .i_cart_data, .i_page_index,
        .i_bank_number, .i_irq_kind,
        .o_item_valid(w_item_valid), .o_item(w_item), .i_item_take(w_item_take)
    );

    hbd_back #(.SPRITE_BYTES(SPRITE_BYTES), .BANK_BITS(BANK_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_item_valid(w_item_valid), .i_item(w_item), .o_item_take(w_item_take),
        .o_valid, .i_ready, .o_read_data, .o_cart_access, .o_cart_address,
        .o_divider_reset, .o_palette_update, .o_dma_busy, .o_dma_next_source,
        .o_irq_flags
    );
endmodule
`default_nettype wire

FILE: hw/rtl/hbd_checker.sv
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks of the bus decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module hbd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_cart_access,
    input wire logic [22:0] o_cart_address,
    input wire logic        o_divider_reset,
    input wire logic        o_palette_update,
    input wire logic [7:0]  o_read_data
);
    // A stalled result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data))
        else $error("result changed while stalled");

    // Cartridge access code never takes the unused value.
    a_cacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cart_access != 2'd3)
        else $error("bad cartridge access code");

    // No cartridge access means a zero address.
    a_caddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cart_access == 2'd0 |-> o_cart_address == 23'd0)
        else $error("address without cartridge access");

    // Divider and palette pulses never come from one transaction.
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_divider_reset && o_palette_update))
        else $error("two side effects at once");
endmodule

bind handheld_bus_decoder_with_oam_dma hbd_checker u_hbd_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_cart_access, .o_cart_address,
    .o_divider_reset, .o_palette_update, .o_read_data
);
`default_nettype wire
